// ===== src/generational_handle_allocator_core_assert.svh =====
// Assertion macros for the generational handle allocator.
// Expects signals clk and rst_n in the including module.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH

// invariant checked at every edge out of reset
`define GHA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("gha: invariant violated");

// implication, consequent checked in the next cycle
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gha: sequence check failed");

// implication, same cycle
`define GHA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gha: implication check failed");

`endif

// ===== src/gha_pkg.sv =====
// Package for the generational handle allocator: widths, op and status codes,
// free-stack entry type. No dependencies.
`default_nettype none

package gha_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int GEN_W      = 16;
  localparam int SIZE_W     = 32;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_QUERY   = 2'd1,
    OP_UPLOAD  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // freed slot together with the generation it will hand out next
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } stack_entry_t;

endpackage

`default_nettype wire

// ===== src/generational_handle_allocator_core.sv =====
// Generational handle allocator core: slot table, free stack, live bits.
// Depends on gha_pkg and generational_handle_allocator_core_assert.svh.
// A request is taken on every cycle (busy stays low) and its result word
// appears with out_valid after the stage 1 and result registers, one word per
// request, in request order; the receiver cannot stall. The first stage reads
// the generation, size and free-stack memories into registers, the second
// checks the handle, updates the tables and loads the result register. Writes
// of the second stage are forwarded to the read of the next request. Live bits
// are flip-flops cleared at reset; the memories need no clearing pass.
`default_nettype none

module generational_handle_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [gha_pkg::SLOT_W-1:0]    in_slot_index,
  input  wire logic [gha_pkg::GEN_W-1:0]     in_handle_generation,
  input  wire logic [gha_pkg::SIZE_W-1:0]    in_buffer_size,
  input  wire logic [gha_pkg::SIZE_W-1:0]    in_upload_offset,
  input  wire logic [gha_pkg::SIZE_W-1:0]    in_upload_stride,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [gha_pkg::SLOT_W-1:0]         out_granted_slot,
  output logic [gha_pkg::GEN_W-1:0]          out_granted_generation,
  output logic [gha_pkg::SIZE_W-1:0]         out_stored_size
);

  `include "generational_handle_allocator_core_assert.svh"

  localparam int SLOT_W = gha_pkg::SLOT_W;
  localparam int CNT_W  = gha_pkg::CNT_W;
  localparam int GEN_W  = gha_pkg::GEN_W;
  localparam int SIZE_W = gha_pkg::SIZE_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(gha_pkg::SLOT_COUNT);

  // memories
  logic [GEN_W-1:0]      gen_mem   [gha_pkg::SLOT_COUNT];
  logic [SIZE_W-1:0]     size_mem  [gha_pkg::SLOT_COUNT];
  gha_pkg::stack_entry_t stack_mem [gha_pkg::SLOT_COUNT];

  logic [gha_pkg::SLOT_COUNT-1:0] live_r;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic [CNT_W-1:0] high_water_r, high_water_nxt;

  // stage 1 registers
  logic                  s1_valid_r;
  gha_pkg::op_t          s1_kind_r;
  logic [SLOT_W-1:0]     s1_slot_r;
  logic [GEN_W-1:0]      s1_gen_r;
  logic [SIZE_W-1:0]     s1_size_r;
  logic [SIZE_W-1:0]     s1_off_r;
  logic [SIZE_W-1:0]     s1_stride_r;
  logic [GEN_W-1:0]      gen_rd_r;
  logic [SIZE_W-1:0]     size_rd_r;
  gha_pkg::stack_entry_t stack_rd_r;

  // result registers
  logic                  out_valid_r;
  gha_pkg::status_t      out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [GEN_W-1:0]      out_gen_r;
  logic [SIZE_W-1:0]     out_size_r;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1 decode
  logic                  is_alloc, pop, fresh, handle_ok, op_ok, range_err;
  logic                  release_ok, push;
  logic [SLOT_W-1:0]     alloc_slot;
  logic [GEN_W-1:0]      alloc_gen, gen_inc;
  logic [SIZE_W:0]       upload_end;

  logic                  gen_we, size_we, stack_we;
  logic [SLOT_W-1:0]     gen_wa, size_wa, stack_wa, stack_ra;
  logic [GEN_W-1:0]      gen_wd;
  gha_pkg::stack_entry_t stack_wd;
  logic [CNT_W-1:0]      free_dec;

  gha_pkg::status_t      status_nxt;
  logic [SLOT_W-1:0]     slot_nxt;
  logic [GEN_W-1:0]      rgen_nxt;
  logic [SIZE_W-1:0]     rsize_nxt;

  always_comb begin
    is_alloc   = (s1_kind_r == gha_pkg::OP_ALLOC);
    pop        = is_alloc && (free_count_r != '0);
    fresh      = is_alloc && !pop && (high_water_r < FULL_CNT);
    alloc_slot = pop ? stack_rd_r.slot : high_water_r[SLOT_W-1:0];
    alloc_gen  = pop ? stack_rd_r.gen : '0;
    handle_ok  = live_r[s1_slot_r] && (gen_rd_r == s1_gen_r);
    op_ok      = !is_alloc && handle_ok;
    upload_end = {1'b0, s1_off_r} + {1'b0, s1_stride_r};
    range_err  = upload_end > {1'b0, size_rd_r};
    gen_inc    = gen_rd_r + GEN_W'(1);
    release_ok = s1_valid_r && op_ok && (s1_kind_r == gha_pkg::OP_RELEASE);
    push       = release_ok && (free_count_r < FULL_CNT);

    gen_we   = s1_valid_r && (fresh || release_ok);
    gen_wa   = fresh ? alloc_slot : s1_slot_r;
    gen_wd   = fresh ? '0 : gen_inc;
    size_we  = s1_valid_r && (pop || fresh);
    size_wa  = alloc_slot;
    stack_we = push;
    stack_wa = free_count_r[SLOT_W-1:0];
    stack_wd.slot = s1_slot_r;
    stack_wd.gen  = gen_inc;

    free_count_nxt = free_count_r;
    high_water_nxt = high_water_r;
    if (s1_valid_r && pop) begin
      free_count_nxt = free_count_r - CNT_W'(1);
    end else if (push) begin
      free_count_nxt = free_count_r + CNT_W'(1);
    end
    if (s1_valid_r && fresh) begin
      high_water_nxt = high_water_r + CNT_W'(1);
    end
    free_dec = free_count_nxt - CNT_W'(1);
    stack_ra = free_dec[SLOT_W-1:0];

    status_nxt = gha_pkg::ST_OK;
    slot_nxt   = s1_slot_r;
    rgen_nxt   = '0;
    rsize_nxt  = '0;
    if (is_alloc) begin
      if (pop || fresh) begin
        slot_nxt  = alloc_slot;
        rgen_nxt  = alloc_gen;
        rsize_nxt = s1_size_r;
      end else begin
        status_nxt = gha_pkg::ST_FULL;
        slot_nxt   = '0;
      end
    end else if (!handle_ok) begin
      status_nxt = gha_pkg::ST_INVALID;
    end else begin
      case (s1_kind_r)
        gha_pkg::OP_QUERY:  rsize_nxt = size_rd_r;
        gha_pkg::OP_UPLOAD: if (range_err) status_nxt = gha_pkg::ST_RANGE;
        default: ;
      endcase
    end
  end

  // memories: registered read with forwarding of the stage 1 write
  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_wa] <= gen_wd;
    if (size_we) size_mem[size_wa] <= s1_size_r;
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    gen_rd_r   <= (gen_we && gen_wa == in_slot_index) ? gen_wd : gen_mem[in_slot_index];
    size_rd_r  <= (size_we && size_wa == in_slot_index) ? s1_size_r
                                                        : size_mem[in_slot_index];
    stack_rd_r <= (stack_we && stack_wa == stack_ra) ? stack_wd : stack_mem[stack_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r   <= gha_pkg::op_t'(in_kind);
      s1_slot_r   <= in_slot_index;
      s1_gen_r    <= in_handle_generation;
      s1_size_r   <= in_buffer_size;
      s1_off_r    <= in_upload_offset;
      s1_stride_r <= in_upload_stride;
    end
    if (s1_valid_r) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_nxt;
      out_gen_r    <= rgen_nxt;
      out_size_r   <= rsize_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      live_r       <= '0;
      free_count_r <= '0;
      high_water_r <= '0;
    end else begin
      s1_valid_r   <= accept;
      out_valid_r  <= s1_valid_r;
      free_count_r <= free_count_nxt;
      high_water_r <= high_water_nxt;
      if (s1_valid_r && (pop || fresh)) live_r[alloc_slot] <= 1'b1;
      if (release_ok) live_r[s1_slot_r] <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_granted_slot       = out_slot_r;
  assign out_granted_generation = out_gen_r;
  assign out_stored_size        = out_size_r;

  `GHA_ASSERT_ALWAYS(a_free_le_hw, free_count_r <= high_water_r)
  `GHA_ASSERT_ALWAYS(a_hw_bound, high_water_r <= FULL_CNT)
  `GHA_ASSERT_NEXT(a_latency, accept, s1_valid_r ##1 out_valid_r)
  `GHA_ASSERT_IMPL(a_full_state,
    out_valid_r && out_status_r == gha_pkg::ST_FULL,
    free_count_r == '0 && high_water_r == FULL_CNT)

endmodule

`default_nettype wire
